/* hdl/trbr_pkg.sv */
`timescale 1ns / 1ps

package trbr_pkg;

    // one result beat
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } rslt_t;

    // results of one accepted input beat, in order: e0 then e1
    typedef struct packed {
        logic [1:0] cnt;
        rslt_t      e0;
        rslt_t      e1;
    } par_out_t;

endpackage

/* hdl/trbr_parser.sv */
`timescale 1ns / 1ps

module trbr_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              first_of_program,
    input  logic [15:0]       offset,
    output trbr_pkg::par_out_t res
);
    import trbr_pkg::*;

    // parser modes
    localparam logic [3:0] M_HEADER    = 4'd0;
    localparam logic [3:0] M_REJECT    = 4'd1;
    localparam logic [3:0] M_END       = 4'd2;
    localparam logic [3:0] M_LINK_LO   = 4'd3;
    localparam logic [3:0] M_LINK_HI   = 4'd4;
    localparam logic [3:0] M_SKIP      = 4'd5;
    localparam logic [3:0] M_STMT      = 4'd6;
    localparam logic [3:0] M_PTR_LO    = 4'd7;
    localparam logic [3:0] M_PTR_HI    = 4'd8;
    localparam logic [3:0] M_COLON     = 4'd9;
    localparam logic [3:0] M_COLON_REM = 4'd10;
    localparam logic [3:0] M_PREFIX_FF = 4'd11;
    localparam logic [3:0] M_AMP       = 4'd12;
    localparam logic [3:0] M_BINARY    = 4'd13;

    // status codes
    localparam logic [1:0] ST_RELOC  = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_END    = 2'd2;

    // token and character codes
    localparam logic [7:0] TOK_EOL     = 8'h00;
    localparam logic [7:0] TOK_SKIP1A  = 8'h01;
    localparam logic [7:0] TOK_SKIP2A  = 8'h0B;
    localparam logic [7:0] TOK_SKIP2B  = 8'h0C;
    localparam logic [7:0] TOK_PTR     = 8'h0D;
    localparam logic [7:0] TOK_SKIP2C  = 8'h0E;
    localparam logic [7:0] TOK_SKIP1B  = 8'h0F;
    localparam logic [7:0] TOK_SKIP2D  = 8'h1C;
    localparam logic [7:0] TOK_SKIP4   = 8'h1D;
    localparam logic [7:0] TOK_SKIP8   = 8'h1F;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_BIN_B    = 8'h42;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_ONE      = 8'h31;
    localparam logic [7:0] TOK_REM     = 8'h8F;
    localparam logic [7:0] TOK_ELSE    = 8'hA1;
    localparam logic [7:0] TOK_APOS    = 8'hE6;
    localparam logic [7:0] TOK_PREFIX  = 8'hFF;
    localparam logic [7:0] HDR_MARK    = 8'hFF;

    typedef struct packed {
        logic [3:0] mode;
        logic [3:0] skip;
        logic       in_string;
        logic       in_remark;
    } pst_t;

    logic [3:0]  mode_reg;
    logic [3:0]  skip_reg;
    logic        in_string_reg;
    logic        in_remark_reg;
    logic [7:0]  held_reg;
    logic [7:0]  held_next;
    pst_t        cur;
    pst_t        st;
    logic        pre_v;
    logic [1:0]  m_cnt;
    rslt_t       m0;
    rslt_t       m1;
    rslt_t       pre;
    logic [15:0] word;
    par_out_t    out_c;

    // parse one ordinary statement byte
    function automatic pst_t stmt_byte(pst_t s, logic [7:0] b);
        pst_t r;
        r = s;
        if (b == TOK_EOL) begin
            r.in_string = 1'b0;
            r.in_remark = 1'b0;
            r.mode      = M_LINK_LO;
        end else begin
            r.mode = M_STMT;
            if (!s.in_remark && s.in_string) begin
                if (b == CH_QUOTE) r.in_string = 1'b0;
            end else if (!s.in_remark) begin
                case (b)
                    CH_QUOTE: r.in_string = 1'b1;
                    TOK_SKIP1A, TOK_SKIP1B: begin
                        r.skip = 4'd1;
                        r.mode = M_SKIP;
                    end
                    TOK_SKIP2A, TOK_SKIP2B, TOK_SKIP2C, TOK_SKIP2D: begin
                        r.skip = 4'd2;
                        r.mode = M_SKIP;
                    end
                    TOK_SKIP4: begin
                        r.skip = 4'd4;
                        r.mode = M_SKIP;
                    end
                    TOK_SKIP8: begin
                        r.skip = 4'd8;
                        r.mode = M_SKIP;
                    end
                    TOK_PTR:    r.mode = M_PTR_LO;
                    CH_AMP:     r.mode = M_AMP;
                    CH_COLON:   r.mode = M_COLON;
                    TOK_REM:    r.in_remark = 1'b1;
                    TOK_PREFIX: r.mode = M_PREFIX_FF;
                    default:    r.mode = M_STMT;
                endcase
            end
        end
        return r;
    endfunction

    assign cur  = '{mode: mode_reg, skip: skip_reg,
                    in_string: in_string_reg, in_remark: in_remark_reg};
    assign word = {data_byte, held_reg} + offset;

    // next parser state and the results of this beat
    always_comb begin
        st        = cur;
        held_next = held_reg;
        pre_v     = 1'b0;
        pre       = '{data: held_reg, last: 1'b0, status: ST_RELOC};
        m_cnt     = 2'd1;
        m0        = '{data: data_byte, last: 1'b0, status: ST_RELOC};
        m1        = '{data: 8'h00, last: 1'b0, status: ST_RELOC};

        // restart: flush a held low byte first
        if (first_of_program) begin
            if (cur.mode == M_LINK_HI || cur.mode == M_PTR_HI) pre_v = 1'b1;
            st.mode = M_HEADER;
        end

        case (st.mode)
            M_HEADER: begin
                st.in_string = 1'b0;
                st.in_remark = 1'b0;
                st.skip      = 4'd0;
                if (data_byte == HDR_MARK) begin
                    m0.data = 8'h00;
                    st.mode = M_LINK_LO;
                end else begin
                    m0.status = ST_REJECT;
                    st.mode   = M_REJECT;
                end
            end
            M_REJECT: m0.status = ST_REJECT;
            M_LINK_LO: begin
                m_cnt     = 2'd0;
                held_next = data_byte;
                st.mode   = M_LINK_HI;
            end
            M_LINK_HI: begin
                m_cnt = 2'd2;
                if (held_reg == 8'h00 && data_byte == 8'h00) begin
                    m0      = '{data: 8'h00, last: 1'b0, status: ST_END};
                    m1      = '{data: 8'h00, last: 1'b0, status: ST_END};
                    st.mode = M_END;
                end else begin
                    m0.data      = word[7:0];
                    m1.data      = word[15:8];
                    st.in_string = 1'b0;
                    st.in_remark = 1'b0;
                    st.skip      = 4'd2;
                    st.mode      = M_SKIP;
                end
            end
            M_SKIP: begin
                if (st.skip != 4'd0) st.skip = st.skip - 4'd1;
                if (st.skip == 4'd0) st.mode = M_STMT;
            end
            M_STMT: st = stmt_byte(st, data_byte);
            M_PTR_LO: begin
                m_cnt     = 2'd0;
                held_next = data_byte;
                st.mode   = M_PTR_HI;
            end
            M_PTR_HI: begin
                m_cnt   = 2'd2;
                m0.data = word[7:0];
                m1.data = word[15:8];
                st.mode = M_STMT;
            end
            M_COLON: begin
                if (data_byte == TOK_ELSE)     st.mode = M_STMT;
                else if (data_byte == TOK_REM) st.mode = M_COLON_REM;
                else                           st = stmt_byte(st, data_byte);
            end
            M_COLON_REM: begin
                if (data_byte == TOK_APOS) begin
                    st.in_remark = 1'b1;
                    st.mode      = M_STMT;
                end else begin
                    st = stmt_byte(st, data_byte);
                end
            end
            M_PREFIX_FF: begin
                if (data_byte inside {8'h3E, [8'h81:8'h8D], [8'h8F:8'hAF], 8'hB0})
                    st.mode = M_STMT;
                else
                    st = stmt_byte(st, data_byte);
            end
            M_AMP: begin
                if (data_byte == CH_BIN_B) st.mode = M_BINARY;
                else                       st = stmt_byte(st, data_byte);
            end
            M_BINARY: begin
                if (data_byte != CH_ZERO && data_byte != CH_ONE)
                    st = stmt_byte(st, data_byte);
            end
            M_END: m0.status = ST_END;
            default: begin
                m0.status = ST_END;
                st.mode   = M_END;
            end
        endcase
    end

    // order the results and flag the final one
    always_comb begin
        out_c = '0;
        if (pre_v) begin
            out_c.e0 = pre;
            out_c.e1 = m0;
            out_c.cnt = 2'd2;
            out_c.e1.last = 1'b1;
        end else begin
            out_c.e0  = m0;
            out_c.e1  = m1;
            out_c.cnt = m_cnt;
            if (m_cnt == 2'd2) out_c.e1.last = 1'b1;
            else               out_c.e0.last = 1'b1;
        end
        if (!accept) out_c.cnt = 2'd0;
    end

    assign res = out_c;

    // advance parser state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= M_HEADER;
            skip_reg      <= 4'd0;
            in_string_reg <= 1'b0;
            in_remark_reg <= 1'b0;
            held_reg      <= 8'h00;
        end else if (accept) begin
            mode_reg      <= st.mode;
            skip_reg      <= st.skip;
            in_string_reg <= st.in_string;
            in_remark_reg <= st.in_remark;
            held_reg      <= held_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_skip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == M_SKIP |-> skip_reg != 4'd0)
        else $error("skip mode with empty skip count");

    a_low_byte_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !first_of_program && (mode_reg == M_LINK_LO || mode_reg == M_PTR_LO))
        |-> res.cnt == 2'd0)
        else $error("low byte of a word was not held");
`endif

endmodule

/* hdl/trbr_outq.sv */
`timescale 1ns / 1ps

module trbr_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  trbr_pkg::par_out_t par,
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output trbr_pkg::rslt_t    m_data
);
    import trbr_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    rslt_t          mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic           pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != CW'(0));
    assign m_data  = mem_reg[rd_ptr_reg];
    // take a new input beat only while two entries are free
    assign room    = (cnt_reg <= CW'(DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(par.cnt);
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(par.cnt) - CW'(pop);
    end

    // write up to two result beats in order
    always_ff @(posedge aclk) begin
        if (par.cnt != 2'd0) mem_reg[wr_ptr_reg] <= par.e0;
        if (par.cnt == 2'd2) mem_reg[wr_ptr_reg + PW'(1)] <= par.e1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("result queue overflow");

    a_count_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (par.cnt == 2'd0 && !pop) |=> $stable(cnt_reg))
        else $error("queue count moved without a push or pop");
`endif

endmodule

/* hdl/tokenized_basic_relocator.sv */
`timescale 1ns / 1ps

// Result beats are registered in a four-entry result queue before they reach the output.
// Throughput: one input beat per cycle while s_ready is high; a link or 0x0D word gives
// its two bytes after its high byte, drained one per cycle while m_ready is high.
// Input ready drops only while the queue holds more than two beats.
// Reset (aresetn low, synchronous): parser expects a header, queue empties, offset is 16.
module tokenized_basic_relocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_of_program,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_of_run,
    output logic [1:0]  m_status
);
    import trbr_pkg::*;

    logic [15:0] offset_reg;
    logic        accept;
    par_out_t    par;
    rslt_t       head;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // hold the address offset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= 16'd16;
        end else if (cfg_valid) begin
            offset_reg <= cfg_data;
        end
    end

    trbr_parser u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .data_byte        (s_data_byte),
        .first_of_program (s_first_of_program),
        .offset           (offset_reg),
        .res              (par)
    );

    trbr_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .par     (par),
        .room    (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (head)
    );

    assign m_out_byte    = head.data;
    assign m_last_of_run = head.last;
    assign m_status      = head.status;

endmodule
